@@ rtl/kcg_pkg.sv @@
package kcg_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int KMAX         = 16;
	localparam int ELEM_W       = 5;
	localparam int POS_W        = 4;
	localparam int CEIL_W       = ELEM_W + 1;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = CFG_IDX_W'(1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MODE_FILL,
		MODE_ADVANCE,
		MODE_EXHAUST
	} mode_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic              shift;
		logic [ELEM_W-1:0] k;
		logic [CEIL_W-1:0] ceil_base;
	} cell_ctrl_t;

endpackage

@@ rtl/kcg_cell.sv @@
module kcg_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [kcg_pkg::POS_W-1:0]  idx,
	input  kcg_pkg::cell_ctrl_t        ctrl,
	input  logic [kcg_pkg::ELEM_W-1:0] right_val,
	input  logic [kcg_pkg::ELEM_W-1:0] wrap_val,
	input  logic                      grow_in,
	output logic [kcg_pkg::ELEM_W-1:0] val,
	output logic                      grow_out,
	output logic                      pivot
);
	import kcg_pkg::*;

	logic [ELEM_W-1:0] elem_q;
	logic              active;
	logic              is_last;
	logic [CEIL_W-1:0] ceiling;
	logic              can_grow;

	assign active   = {1'b0, idx} < ctrl.k;
	assign is_last  = {1'b0, idx} == (ctrl.k - ELEM_W'(1));
	// ceiling of position idx is n - k + idx + 1
	assign ceiling  = ctrl.ceil_base + CEIL_W'(idx);
	assign can_grow = active && ({1'b0, elem_q} < ceiling);

	// rightmost growing cell: nothing to its right can grow
	assign grow_out = grow_in | can_grow;
	assign pivot    = can_grow & ~grow_in;
	assign val      = elem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= '0;
		end else if (ctrl.shift && active) begin
			elem_q <= is_last ? wrap_val : right_val;
		end
	end

endmodule

@@ rtl/k_combination_generator.sv @@
// Lexicographic k-combination generator over the elements 1..n.
// Configuration: set_size (index 0) and choose_count (index 1) are written through
// cfg_wen/cfg_index/cfg_data; the user must write them only while the block is
// idle; the block does not enforce it. A write to either restarts the enumeration
// from 1..k on the next request. Input channel (in_valid/in_ready): one transaction per
// request, restart=1 gives the first combination, restart=0 the next one.
// Output channel (out_valid/out_ready): k transactions per request, smallest
// element first, the final one flagged by last_of_combination. When no
// combination is left, or k is outside 1..min(n,16), a single transaction
// with exhausted=1 is given instead.
// A request is taken while the block is idle; its results leave through the
// output register one per cycle while the receiver does not stall. The
// elements sit in a ring of cells that rotates once per emitted element;
// the pivot search runs while idle and the refill is applied at the ring's
// wrap point.
// A stall of out_ready freezes the ring; the next request is taken as soon
// as the final result of the current one is in the output register.
// Reset clears the ring, the started/done flags and the output valid flag,
// and loads n=5, k=3.
module k_combination_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [kcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kcg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kcg_pkg::ELEM_W-1:0]     element,
	output logic [kcg_pkg::POS_W-1:0]      position,
	output logic                          last_of_combination,
	output logic                          exhausted
);
	import kcg_pkg::*;

	logic [ELEM_W-1:0] set_size_q;
	logic [ELEM_W-1:0] choose_count_q;
	logic              started_q;
	logic              done_q;
	state_t            state_q;
	state_t            state_d;
	mode_t             mode_q;
	logic [POS_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pivot_q;
	logic [ELEM_W-1:0] prev_q;

	logic              out_valid_q;
	logic [ELEM_W-1:0] element_q;
	logic [POS_W-1:0]  position_q;
	logic              last_q;
	logic              exhausted_q;

	logic              accept;
	logic              step;
	logic              emit_end;
	logic              is_final;
	logic [ELEM_W-1:0] n_eff;
	logic              k_ok;
	logic [ELEM_W-1:0] new_val;
	cell_ctrl_t        ctrl;

	logic [ELEM_W-1:0] cell_val [KMAX];
	logic              grow     [KMAX+1];
	logic [KMAX-1:0]   pivot_vec;
	logic [POS_W-1:0]  pivot_idx;

	assign n_eff = (32'(set_size_q) > MAX_ELEMENTS) ? ELEM_W'(MAX_ELEMENTS) : set_size_q;
	assign k_ok  = (choose_count_q != '0) && (choose_count_q <= n_eff)
		&& (32'(choose_count_q) <= KMAX);

	assign ctrl.shift     = step && (mode_q != MODE_EXHAUST);
	assign ctrl.k         = choose_count_q;
	assign ctrl.ceil_base = {1'b0, n_eff} - {1'b0, choose_count_q} + CEIL_W'(1);

	assign grow[KMAX] = 1'b0;

	for (genvar i = 0; i < KMAX; i++) begin : g_cell
		logic [ELEM_W-1:0] right;
		if (i == KMAX - 1) begin : g_end
			assign right = '0;
		end else begin : g_mid
			assign right = cell_val[i+1];
		end
		kcg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (POS_W'(i)),
			.ctrl     (ctrl),
			.right_val(right),
			.wrap_val (new_val),
			.grow_in  (grow[i+1]),
			.val      (cell_val[i]),
			.grow_out (grow[i]),
			.pivot    (pivot_vec[i])
		);
	end

	always_comb begin
		pivot_idx = '0;
		for (int i = 0; i < KMAX; i++) begin
			if (pivot_vec[i]) begin
				pivot_idx = pivot_idx | POS_W'(i);
			end
		end
	end

	// value emitted and written back at the wrap point in place of the element leaving cell 0
	always_comb begin
		unique case (mode_q)
			MODE_FILL: new_val = ELEM_W'(cnt_q) + ELEM_W'(1);
			MODE_ADVANCE: begin
				priority if (cnt_q < pivot_q) begin
					new_val = cell_val[0];
				end else if (cnt_q == pivot_q) begin
					new_val = cell_val[0] + ELEM_W'(1);
				end else begin
					new_val = prev_q + ELEM_W'(1);
				end
			end
			default: new_val = '0;
		endcase
	end

	assign is_final = (mode_q == MODE_EXHAUST)
		|| ({1'b0, cnt_q} == (choose_count_q - ELEM_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EMIT;
			ST_EMIT: if (step && is_final) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		step     = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT: step = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept   = in_valid && in_ready;
	assign emit_end = step && is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q     <= ELEM_W'(5);
			choose_count_q <= ELEM_W'(3);
			started_q      <= 1'b0;
			done_q         <= 1'b0;
			mode_q         <= MODE_FILL;
			cnt_q          <= '0;
			pivot_q        <= '0;
		end else begin
			if (accept) begin
				cnt_q   <= '0;
				pivot_q <= pivot_idx;
				priority if (!k_ok) begin
					mode_q    <= MODE_EXHAUST;
					started_q <= 1'b1;
					done_q    <= 1'b1;
				end else if (restart || !started_q) begin
					mode_q    <= MODE_FILL;
					started_q <= 1'b1;
					done_q    <= 1'b0;
				end else if (done_q) begin
					mode_q <= MODE_EXHAUST;
				end else if (pivot_vec == '0) begin
					mode_q <= MODE_EXHAUST;
					done_q <= 1'b1;
				end else begin
					mode_q <= MODE_ADVANCE;
				end
			end else if (step && !emit_end) begin
				cnt_q <= cnt_q + POS_W'(1);
			end
			if (cfg_wen) begin
				if (cfg_index == REG_SET_SIZE) begin
					set_size_q <= cfg_data;
					started_q  <= 1'b0;
					done_q     <= 1'b0;
				end else if (cfg_index == REG_CHOOSE_COUNT) begin
					choose_count_q <= cfg_data;
					started_q      <= 1'b0;
					done_q         <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			prev_q <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			element_q   <= new_val;
			position_q  <= (mode_q == MODE_EXHAUST) ? '0 : cnt_q;
			last_q      <= is_final;
			exhausted_q <= (mode_q == MODE_EXHAUST);
		end
	end

	assign out_valid           = out_valid_q;
	assign element             = element_q;
	assign position            = position_q;
	assign last_of_combination = last_q;
	assign exhausted           = exhausted_q;

endmodule

@@ rtl/kcg_checker.sv @@
module kcg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [kcg_pkg::ELEM_W-1:0]     element,
	input logic [kcg_pkg::POS_W-1:0]      position,
	input logic                          last_of_combination,
	input logic                          exhausted
);
	import kcg_pkg::*;

	// a pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element) && $stable(position)
			&& $stable(last_of_combination) && $stable(exhausted))
		else $error("output transaction changed while stalled");

	a_exh_format: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exhausted |-> element == '0 && position == '0 && last_of_combination)
		else $error("malformed exhausted result");

	a_elem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !exhausted |-> element != '0)
		else $error("zero element in a combination");

	// more elements of this combination are still due
	a_no_req_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_combination |-> !in_ready)
		else $error("request taken in the middle of a combination");

endmodule

bind k_combination_generator kcg_checker u_kcg_checker (.*);
